### rtl/ptq_pkg.sv
package ptq_pkg;

  localparam int unsigned SlotsDef = 32;
  localparam int unsigned SlotIdW  = 6;
  localparam int unsigned TicksW   = 32;
  localparam int unsigned TargetW  = 15;

  typedef enum logic [1:0] {
    FUNC_CREATE = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_TICK   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    KIND_CREATE = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_EXPIRY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_ARG   = 2'd1,
    STAT_NO_SLOT   = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CREATE,
    S_SCAN,
    S_FLUSH
  } state_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [TicksW-1:0]  start_ticks;
    logic [TicksW-1:0]  cycle_ticks;
    logic [TargetW-1:0] target_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [SlotIdW-1:0] slot_id;
    logic [1:0]         status;
    logic               last;
  } res_item_t;

  typedef struct packed {
    logic arm;
    logic disarm;
  } cell_cmd_t;

  typedef struct packed {
    logic armed;
    logic fire;
    logic one_shot;
  } cell_stat_t;

endpackage

### rtl/periodic_timer_queue.sv
// Channel  Handshake              Payload     Notes
// command  start / busy           in_i        taken when start is high and busy is low
// result   res_valid_o (strobe)   res_o       valid for one cycle, cannot be held off
//
// Delete and rejected create: answered in the cycle after the command is taken. Create
// that takes a slot: answered from S_CREATE, after the registered read of the free-id stack.
// Tick: S_SCAN, then S_FLUSH; a token walks the row of slot cells one per cycle.
// Results are registered and appear in the cycle after the decision that makes them.
// Reset: all slots disarmed, free stack full with id 0 on top; no clearing pass.
// The result side has no back-pressure; busy alone paces the command side.
module periodic_timer_queue #(
  parameter int unsigned SLOTS = ptq_pkg::SlotsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  ptq_pkg::in_item_t  in_i,
  output logic               res_valid_o,
  output ptq_pkg::res_item_t res_o
);
  import ptq_pkg::*;

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CntW = $clog2(SLOTS + 1);

  state_e            state_q, state_d;
  logic [CntW-1:0]   free_cnt_q, free_cnt_d;
  logic [IdxW-1:0]   scan_q, scan_d;
  logic              held_q, held_d;
  logic [IdxW-1:0]   held_id_q, held_id_d;
  logic [TicksW-1:0] start_q, cycle_q;
  logic              res_valid_q, res_valid_d;
  res_item_t         res_q, res_d;

  logic              accept;
  logic [TicksW-1:0] eff_start;
  logic              tgt_ok;
  logic [IdxW-1:0]   tgt_idx;
  logic              tgt_armed;
  logic              load_args;
  logic              inject;
  logic              arm_en, disarm_en;
  logic              push;
  logic [IdxW-1:0]   push_id;
  logic              rd_en;
  logic [IdxW-1:0]   pop_id;
  logic              fire_any, one_shot_any;

  logic [SLOTS:0]    tok;
  cell_cmd_t         cmd   [SLOTS];
  cell_stat_t        stat  [SLOTS];
  logic [SLOTS-1:0]  armed_vec, fire_vec, one_shot_vec;

  function automatic res_item_t mk_res(kind_e k, logic [SlotIdW-1:0] id, status_e s,
                                       logic l);
    res_item_t r;
    r.kind    = k;
    r.slot_id = id;
    r.status  = s;
    r.last    = l;
    return r;
  endfunction

  assign busy      = (state_q != S_IDLE);
  assign accept    = start && !busy;
  assign eff_start = (in_i.start_ticks != '0) ? in_i.start_ticks : in_i.cycle_ticks;
  assign tgt_ok    = (in_i.target_id < TargetW'(SLOTS));
  assign tgt_idx   = in_i.target_id[IdxW-1:0];
  assign tgt_armed = armed_vec[tgt_idx];
  assign tok[0]    = inject;

  ptq_stack #(
    .SLOTS (SLOTS),
    .IDX_W (IdxW)
  ) u_stack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_addr_i (free_cnt_q[IdxW-1:0]),
    .push_id_i (push_id),
    .rd_en_i   (rd_en),
    .rd_addr_i (IdxW'(free_cnt_q - 1'b1)),
    .rd_id_o   (pop_id)
  );

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    assign cmd[g].arm    = arm_en && (pop_id == IdxW'(g));
    assign cmd[g].disarm = disarm_en && (tgt_idx == IdxW'(g));

    ptq_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1]),
      .cmd_i    (cmd[g]),
      .start_i  (start_q),
      .period_i (cycle_q),
      .stat_o   (stat[g])
    );

    assign armed_vec[g]    = stat[g].armed;
    assign fire_vec[g]     = stat[g].fire;
    assign one_shot_vec[g] = stat[g].one_shot;
  end

  assign fire_any     = |fire_vec;
  assign one_shot_any = |(fire_vec & one_shot_vec);

  always_comb begin
    state_d     = state_q;
    free_cnt_d  = free_cnt_q;
    scan_d      = scan_q;
    held_d      = held_q;
    held_id_d   = held_id_q;
    res_valid_d = 1'b0;
    res_d       = '0;
    load_args   = 1'b0;
    inject      = 1'b0;
    arm_en      = 1'b0;
    disarm_en   = 1'b0;
    push        = 1'b0;
    push_id     = '0;
    rd_en       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_i.func)
            FUNC_CREATE: begin
              res_valid_d = 1'b1;
              if (eff_start == '0) begin
                res_d = mk_res(KIND_CREATE, '0, STAT_BAD_ARG, 1'b1);
              end else if (free_cnt_q == '0) begin
                res_d = mk_res(KIND_CREATE, '0, STAT_NO_SLOT, 1'b1);
              end else begin
                // pop now, answer once the id is out of the stack
                res_valid_d = 1'b0;
                rd_en       = 1'b1;
                load_args   = 1'b1;
                free_cnt_d  = free_cnt_q - 1'b1;
                state_d     = S_CREATE;
              end
            end
            FUNC_DELETE: begin
              res_valid_d = 1'b1;
              if (!tgt_ok) begin
                res_d = mk_res(KIND_DELETE, '0, STAT_BAD_ARG, 1'b1);
              end else if (!tgt_armed) begin
                res_d = mk_res(KIND_DELETE, in_i.target_id[SlotIdW-1:0], STAT_NOT_FOUND,
                               1'b1);
              end else begin
                disarm_en  = 1'b1;
                push       = 1'b1;
                push_id    = tgt_idx;
                free_cnt_d = free_cnt_q + 1'b1;
                res_d      = mk_res(KIND_DELETE, in_i.target_id[SlotIdW-1:0], STAT_OK,
                                    1'b1);
              end
            end
            FUNC_TICK: begin
              inject  = 1'b1;
              scan_d  = '0;
              held_d  = 1'b0;
              state_d = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_CREATE: begin
        arm_en      = 1'b1;
        res_valid_d = 1'b1;
        res_d       = mk_res(KIND_CREATE, SlotIdW'(pop_id), STAT_OK, 1'b1);
        state_d     = S_IDLE;
      end
      S_SCAN: begin
        scan_d = scan_q + 1'b1;
        if (fire_any) begin
          // hold each expiry until the next one shows it was not the last
          if (held_q) begin
            res_valid_d = 1'b1;
            res_d       = mk_res(KIND_EXPIRY, SlotIdW'(held_id_q), STAT_OK, 1'b0);
          end
          held_d    = 1'b1;
          held_id_d = scan_q;
          if (one_shot_any) begin
            push       = 1'b1;
            push_id    = scan_q;
            free_cnt_d = free_cnt_q + 1'b1;
          end
        end
        if (tok[SLOTS]) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (held_q) begin
          res_valid_d = 1'b1;
          res_d       = mk_res(KIND_EXPIRY, SlotIdW'(held_id_q), STAT_OK, 1'b1);
        end
        held_d  = 1'b0;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_cnt_q  <= CntW'(SLOTS);
      scan_q      <= '0;
      held_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_cnt_q  <= free_cnt_d;
      scan_q      <= scan_d;
      held_q      <= held_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_id_q <= held_id_d;
    res_q     <= res_d;
    if (load_args) begin
      start_q <= eff_start;
      cycle_q <= in_i.cycle_ticks;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_scan_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> $onehot(tok[SLOTS:1]))
    else $error("scan token lost or duplicated");

  a_idle_no_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (tok[SLOTS:1] == '0))
    else $error("scan token left in the row while idle");

  a_single_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(fire_vec))
    else $error("more than one slot fires at once");

  a_free_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_cnt_q <= CntW'(SLOTS))
    else $error("free count above slot count");

  a_create_from_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_q.kind == KIND_CREATE) && (res_q.status == STAT_OK))
      |-> ($past(state_q) == S_CREATE))
    else $error("create answer without a stack pop");

endmodule

### rtl/ptq_cell.sv
module ptq_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       tok_i,
  output logic                       tok_o,
  input  ptq_pkg::cell_cmd_t         cmd_i,
  input  logic [ptq_pkg::TicksW-1:0] start_i,
  input  logic [ptq_pkg::TicksW-1:0] period_i,
  output ptq_pkg::cell_stat_t        stat_o
);
  import ptq_pkg::*;

  logic              tok_q;
  logic              armed_q, armed_d;
  logic [TicksW-1:0] rem_q, rem_d;
  logic [TicksW-1:0] per_q, per_d;
  logic [TicksW-1:0] rem_m1;
  logic              expire;

  always_comb begin
    rem_m1  = rem_q - 1'b1;
    expire  = tok_q && armed_q && (rem_m1 == '0);
    armed_d = armed_q;
    rem_d   = rem_q;
    per_d   = per_q;
    if (cmd_i.arm) begin
      armed_d = 1'b1;
      rem_d   = start_i;
      per_d   = period_i;
    end else if (cmd_i.disarm) begin
      armed_d = 1'b0;
    end else if (tok_q && armed_q) begin
      if (expire) begin
        // reload a periodic slot, drop a one-shot one
        if (per_q != '0) begin
          rem_d = per_q;
        end else begin
          armed_d = 1'b0;
        end
      end else begin
        rem_d = rem_m1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= 1'b0;
      armed_q <= 1'b0;
    end else begin
      tok_q   <= tok_i;
      armed_q <= armed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    per_q <= per_d;
  end

  assign tok_o           = tok_q;
  assign stat_o.armed    = armed_q;
  assign stat_o.fire     = expire;
  assign stat_o.one_shot = (per_q == '0);

  a_armed_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> (rem_q != '0))
    else $error("armed slot holds zero ticks");

endmodule

### rtl/ptq_stack.sv
module ptq_stack #(
  parameter int unsigned SLOTS = ptq_pkg::SlotsDef,
  parameter int unsigned IDX_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  logic [IDX_W-1:0] push_id_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output logic [IDX_W-1:0] rd_id_o
);
  import ptq_pkg::*;

  logic [IDX_W-1:0] mem [SLOTS];
  logic [SLOTS-1:0] written_q;
  logic [IDX_W-1:0] rd_q;
  logic [IDX_W-1:0] rd_addr_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_addr_i] <= push_id_i;
    end
    if (rd_en_i) begin
      rd_q      <= mem[rd_addr_i];
      rd_addr_q <= rd_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (push_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= written_q[rd_addr_i];
      end
    end
  end

  // an entry never written holds its reset id, which puts id 0 on top
  assign rd_id_o = rd_vld_q ? rd_q : (IDX_W'(SLOTS - 1) - rd_addr_q);

endmodule
